[rtl/imm_pkg.sv]
// Shared types, constants and codes for the integer matrix multiplier.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
`default_nettype none

package imm_pkg;

  localparam int DefMaxRows   = 8;
  localparam int DefMaxCommon = 8;
  localparam int DefMaxCols   = 8;

  localparam int ElemW  = 16;
  localparam int SumW   = 35;
  localparam int ActW   = 2;
  localparam int RowW   = 3;
  localparam int ColW   = 3;
  localparam int CfgW   = 4;
  localparam int CfgIdxW = 2;
  localparam int CntW   = CfgW;

  localparam logic [ActW-1:0] ActLoadA   = 2'd0;
  localparam logic [ActW-1:0] ActLoadB   = 2'd1;
  localparam logic [ActW-1:0] ActCompute = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgIdxRows   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxCommon = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxCols   = 2'd2;

  localparam logic [CfgW-1:0] RstRows   = 4'd6;
  localparam logic [CfgW-1:0] RstCommon = 4'd5;
  localparam logic [CfgW-1:0] RstCols   = 4'd4;

  typedef struct packed {
    logic            wr_a;
    logic            wr_b;
    logic            rd_en;
    logic            first;
    logic [CntW-1:0] r;
    logic [CntW-1:0] c;
    logic [CntW-1:0] k;
    logic            load_out;
    logic            out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/imm_in_if.sv]
// Input channel: valid/ready handshake carrying one load or compute transaction.
// Depends on imm_pkg.
`default_nettype none

interface imm_in_if;
  import imm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ActW-1:0]         action;
  logic [RowW-1:0]         row;
  logic [ColW-1:0]         col;
  logic signed [ElemW-1:0] element_value;

  modport source (output valid, action, row, col, element_value, input ready);
  modport sink   (input valid, action, row, col, element_value, output ready);
endinterface

`default_nettype wire

[rtl/imm_out_if.sv]
// Output channel: valid/ready handshake carrying one product element per transaction.
// Depends on imm_pkg.
`default_nettype none

interface imm_out_if;
  import imm_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [RowW-1:0]        result_row;
  logic [ColW-1:0]        result_col;
  logic signed [SumW-1:0] product_sum;
  logic                   last_of_run;

  modport source (output valid, result_row, result_col, product_sum, last_of_run,
                  input ready);
  modport sink   (input valid, result_row, result_col, product_sum, last_of_run,
                  output ready);
endinterface

`default_nettype wire

[rtl/imm_ctrl.sv]
// Controller: size registers, load decode and the sequencer that walks r, c and k.
// Depends on imm_pkg; drives the datapath through ctrl_cmd_t.
`default_nettype none

module imm_ctrl #(
  parameter int MAX_ROWS   = imm_pkg::DefMaxRows,
  parameter int MAX_COMMON = imm_pkg::DefMaxCommon,
  parameter int MAX_COLS   = imm_pkg::DefMaxCols
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [imm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [imm_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  input  logic [imm_pkg::ActW-1:0]     in_action_i,
  input  logic [imm_pkg::RowW-1:0]     in_row_i,
  input  logic [imm_pkg::ColW-1:0]     in_col_i,
  output logic                         in_ready_o,
  output imm_pkg::ctrl_cmd_t           cmd_o,
  input  imm_pkg::dp_status_t          stat_i
);
  import imm_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StIssue = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;
  localparam logic [1:0] StEmit  = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CfgW-1:0] rows_q, rows_d, common_q, common_d, cols_q, cols_d;
  logic [CntW-1:0] r_q, r_d, c_q, c_d, k_q, k_d;
  logic            drain_q, drain_d;
  logic [CntW-1:0] nr, nk, nc;
  logic            accept, last_k, last_r, last_c;

  always_comb begin
    nr = (rows_q == '0) ? CntW'(1) :
         (int'(rows_q) > MAX_ROWS) ? CntW'(MAX_ROWS) : rows_q;
    nk = (common_q == '0) ? CntW'(1) :
         (int'(common_q) > MAX_COMMON) ? CntW'(MAX_COMMON) : common_q;
    nc = (cols_q == '0) ? CntW'(1) :
         (int'(cols_q) > MAX_COLS) ? CntW'(MAX_COLS) : cols_q;
  end

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign last_k     = (k_q == nk - CntW'(1));
  assign last_r     = (r_q == nr - CntW'(1));
  assign last_c     = (c_q == nc - CntW'(1));

  always_comb begin
    rows_d   = rows_q;
    common_d = common_q;
    cols_d   = cols_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIdxRows:   rows_d   = cfg_data_i;
        CfgIdxCommon: common_d = cfg_data_i;
        CfgIdxCols:   cols_d   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    c_d     = c_q;
    k_d     = k_q;
    drain_d = drain_q;

    cmd_o          = '0;
    cmd_o.r        = r_q;
    cmd_o.c        = c_q;
    cmd_o.k        = k_q;
    cmd_o.first    = (k_q == '0);
    cmd_o.out_last = last_r && last_c;
    cmd_o.wr_a     = accept && (in_action_i == ActLoadA) &&
                     ({1'b0, in_row_i} < nr) && ({1'b0, in_col_i} < nk);
    cmd_o.wr_b     = accept && (in_action_i == ActLoadB) &&
                     ({1'b0, in_row_i} < nk) && ({1'b0, in_col_i} < nc);

    unique case (state_q)
      StIdle: begin
        if (accept && (in_action_i == ActCompute)) begin
          r_d     = '0;
          c_d     = '0;
          k_d     = '0;
          state_d = StIssue;
        end
      end
      StIssue: begin
        cmd_o.rd_en = 1'b1;
        k_d         = k_q + CntW'(1);
        if (last_k) begin
          drain_d = 1'b0;
          state_d = StDrain;
        end
      end
      StDrain: begin
        drain_d = 1'b1;
        if (drain_q) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          k_d            = '0;
          if (last_r && last_c) begin
            state_d = StIdle;
          end else begin
            state_d = StIssue;
            if (last_c) begin
              c_d = '0;
              r_d = r_q + CntW'(1);
            end else begin
              c_d = c_q + CntW'(1);
            end
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      rows_q   <= RstRows;
      common_q <= RstCommon;
      cols_q   <= RstCols;
      r_q      <= '0;
      c_q      <= '0;
      k_q      <= '0;
      drain_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rows_q   <= rows_d;
      common_q <= common_d;
      cols_q   <= cols_d;
      r_q      <= r_d;
      c_q      <= c_d;
      k_q      <= k_d;
      drain_q  <= drain_d;
    end
  end

endmodule

`default_nettype wire

[rtl/imm_dp.sv]
// Datapath: A and B element memories, registered multiplier, accumulator and output register.
// Depends on imm_pkg; commanded by imm_ctrl through ctrl_cmd_t.
`default_nettype none

module imm_dp #(
  parameter int MAX_ROWS   = imm_pkg::DefMaxRows,
  parameter int MAX_COMMON = imm_pkg::DefMaxCommon,
  parameter int MAX_COLS   = imm_pkg::DefMaxCols
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  imm_pkg::ctrl_cmd_t               cmd_i,
  output imm_pkg::dp_status_t              stat_o,
  input  logic [imm_pkg::RowW-1:0]         in_row_i,
  input  logic [imm_pkg::ColW-1:0]         in_col_i,
  input  logic signed [imm_pkg::ElemW-1:0] in_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [imm_pkg::RowW-1:0]         out_row_o,
  output logic [imm_pkg::ColW-1:0]         out_col_o,
  output logic signed [imm_pkg::SumW-1:0]  out_sum_o,
  output logic                             out_last_o
);
  import imm_pkg::*;

  localparam int DepthA = MAX_ROWS * MAX_COMMON;
  localparam int DepthB = MAX_COMMON * MAX_COLS;
  localparam int AwA    = (DepthA > 1) ? $clog2(DepthA) : 1;
  localparam int AwB    = (DepthB > 1) ? $clog2(DepthB) : 1;

  logic signed [ElemW-1:0]   mem_a [DepthA];
  logic signed [ElemW-1:0]   mem_b [DepthB];
  logic [AwA-1:0]            wr_addr_a, rd_addr_a;
  logic [AwB-1:0]            wr_addr_b, rd_addr_b;
  logic signed [ElemW-1:0]   a_q, b_q;
  logic signed [2*ElemW-1:0] prod_q;
  logic signed [SumW-1:0]    acc_q, acc_d;
  logic                      s1_vld_q, s1_first_q, s2_vld_q, s2_first_q;
  logic                      out_vld_q;
  logic [RowW-1:0]           out_row_q;
  logic [ColW-1:0]           out_col_q;
  logic signed [SumW-1:0]    out_sum_q;
  logic                      out_last_q;

  assign wr_addr_a = AwA'(int'(in_row_i) * MAX_COMMON + int'(in_col_i));
  assign wr_addr_b = AwB'(int'(in_row_i) * MAX_COLS + int'(in_col_i));
  assign rd_addr_a = AwA'(int'(cmd_i.r) * MAX_COMMON + int'(cmd_i.k));
  assign rd_addr_b = AwB'(int'(cmd_i.k) * MAX_COLS + int'(cmd_i.c));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a) begin
      mem_a[wr_addr_a] <= in_value_i;
    end
    if (cmd_i.rd_en) begin
      a_q <= mem_a[rd_addr_a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_b) begin
      mem_b[wr_addr_b] <= in_value_i;
    end
    if (cmd_i.rd_en) begin
      b_q <= mem_b[rd_addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_q * b_q;
  end

  always_comb begin
    acc_d = acc_q;
    if (s2_vld_q) begin
      acc_d = (s2_first_q ? SumW'(0) : acc_q) + SumW'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s1_first_q <= 1'b0;
      s2_vld_q   <= 1'b0;
      s2_first_q <= 1'b0;
      acc_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      s1_vld_q   <= cmd_i.rd_en;
      s1_first_q <= cmd_i.first;
      s2_vld_q   <= s1_vld_q;
      s2_first_q <= s1_first_q;
      acc_q      <= acc_d;
      if (cmd_i.load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_row_q  <= cmd_i.r[RowW-1:0];
      out_col_q  <= cmd_i.c[ColW-1:0];
      out_sum_q  <= acc_q;
      out_last_q <= cmd_i.out_last;
    end
  end

  assign stat_o.out_free = !out_vld_q || out_ready_i;
  assign out_valid_o     = out_vld_q;
  assign out_row_o       = out_row_q;
  assign out_col_o       = out_col_q;
  assign out_sum_o       = out_sum_q;
  assign out_last_o      = out_last_q;

endmodule

`default_nettype wire

[rtl/integer_matrix_multiply.sv]
// Integer matrix multiplier: top level joining controller and datapath.
// Depends on imm_pkg, imm_in_if, imm_out_if, imm_ctrl and imm_dp.
//
// Usage:
//  - in_chan_i takes one transaction per cycle while the block is idle: load A
//    element, load B element, or compute. Loads complete in the accepting cycle;
//    a load whose row or column lies outside the sizes in use is dropped.
//  - A compute transaction emits rows*cols results on out_chan_o in row-major
//    order, the final one with last_of_run set. Each element passes through
//    common memory reads (one A and one B read port, one product per cycle),
//    the multiply/accumulate pipeline (read registers, product register,
//    accumulator) and a move of the sum into the output register;
//    in_chan_i.ready is low throughout a run.
//  - The output register holds a result until taken. A stalled receiver stalls
//    the sequencer at the next element; the following transaction is accepted as
//    soon as the last result sits in the output register.
//  - The cfg port writes the size registers (rows, common, cols);
//    write only while idle. Reset sets sizes 6, 5, 4 and empties the output;
//    the element memories hold nothing defined until loaded.
`default_nettype none

module integer_matrix_multiply #(
  parameter int MAX_ROWS   = imm_pkg::DefMaxRows,
  parameter int MAX_COMMON = imm_pkg::DefMaxCommon,
  parameter int MAX_COLS   = imm_pkg::DefMaxCols
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [imm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [imm_pkg::CfgW-1:0]    cfg_data_i,
  imm_in_if.sink                      in_chan_i,
  imm_out_if.source                   out_chan_o
);
  import imm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_stat;
  logic       in_ready;

  imm_ctrl #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COMMON (MAX_COMMON),
    .MAX_COLS   (MAX_COLS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_chan_i.valid),
    .in_action_i (in_chan_i.action),
    .in_row_i    (in_chan_i.row),
    .in_col_i    (in_chan_i.col),
    .in_ready_o  (in_ready),
    .cmd_o       (cmd),
    .stat_i      (dp_stat)
  );

  assign in_chan_i.ready = in_ready;

  imm_dp #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COMMON (MAX_COMMON),
    .MAX_COLS   (MAX_COLS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (dp_stat),
    .in_row_i    (in_chan_i.row),
    .in_col_i    (in_chan_i.col),
    .in_value_i  (in_chan_i.element_value),
    .out_valid_o (out_chan_o.valid),
    .out_ready_i (out_chan_o.ready),
    .out_row_o   (out_chan_o.result_row),
    .out_col_o   (out_chan_o.result_col),
    .out_sum_o   (out_chan_o.product_sum),
    .out_last_o  (out_chan_o.last_of_run)
  );

  a_load_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_chan_o.valid || out_chan_o.ready))
    else $error("result loaded over an untaken result");

  a_no_input_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en |-> !in_ready)
    else $error("input ready while computing");

  a_compute_goes_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_chan_i.valid && in_ready && (in_chan_i.action == ActCompute)) |=> !in_ready)
    else $error("compute transaction did not start a run");

  a_last_returns_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_out && cmd.out_last) |=> (in_ready && out_chan_o.valid &&
                                        out_chan_o.last_of_run))
    else $error("run did not end cleanly after last result");

endmodule

`default_nettype wire
